// File: sv/tkfc_pkg.sv
// Types, constants and register codes shared by the thermostat fan controller.
package tkfc_pkg;

  localparam int TEMP_W     = 8;
  localparam int SP_W       = 7;
  localparam int DUTY_W     = 8;
  localparam int SPAN_W     = 8;
  localparam int GAIN_W     = 7;
  localparam int KEY_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int DIGIT_W    = 4;

  localparam int MAX_DIGITS_DEF = 2;

  localparam logic [KEY_W-1:0]  KEY_ZERO   = 8'h30;
  localparam logic [KEY_W-1:0]  KEY_NINE   = 8'h39;
  localparam logic [KEY_W-1:0]  KEY_COMMIT = 8'h3D;
  localparam logic [DUTY_W-1:0] DUTY_CEILING = 8'd150;

  localparam logic [SP_W-1:0]   MIN_SP_RST   = 7'd15;
  localparam logic [SP_W-1:0]   MAX_SP_RST   = 7'd30;
  localparam logic [SP_W-1:0]   DEF_SP_RST   = 7'd25;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 7'd10;
  localparam logic [SPAN_W-1:0] SPAN_RST     = 8'd10;
  localparam logic [SP_W-1:0]   FULL_DUTY_RST = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SP    = 3'd0,
    REG_MAX_SP    = 3'd1,
    REG_DEF_SP    = 3'd2,
    REG_GAIN      = 3'd3,
    REG_SPAN      = 3'd4,
    REG_FULL_DUTY = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ENTRY_NONE     = 2'd0,
    ENTRY_ACCEPTED = 2'd1,
    ENTRY_REJECTED = 2'd2
  } entry_status_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              key_valid;
    logic [KEY_W-1:0]  key_code;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] fan_duty;
    entry_status_t     entry_status;
    logic              show_measured;
    logic [SP_W-1:0]   active_setpoint;
  } out_item_t;

  // Fan law settings handed to the duty unit
  typedef struct packed {
    logic [GAIN_W-1:0] duty_per_degree;
    logic [SPAN_W-1:0] proportional_span;
    logic [SP_W-1:0]   full_duty;
  } fan_cfg_t;

endpackage

// File: sv/thermostat_keypad_fan_control.sv
// Thermostat with keypad setpoint entry and proportional fan drive.
// Pipeline: an accepted item passes the input register and then the result register,
// whose load raises out_valid for it.
// Throughput: one item per cycle; a stalled result holds both registers, and in_ready drops
// once the input register is occupied as well.
// Reset (rst, synchronous): clears both pipeline valids and the digit buffer,
// loads the register defaults, sets the setpoint to 25 and the display to measured.
module thermostat_keypad_fan_control import tkfc_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // Configuration registers
  logic [SP_W-1:0] min_setpoint;
  logic [SP_W-1:0] max_setpoint;
  logic [SP_W-1:0] default_setpoint;
  fan_cfg_t        fan_cfg;

  // Control state
  logic [DIGIT_W-1:0] entered_digits [MAX_DIGITS];
  logic [DIGIT_W-1:0] entered_digits_next [MAX_DIGITS];
  logic [CNT_W-1:0]   digits_held, digits_held_next;
  logic [SP_W-1:0]    setpoint, setpoint_next;
  logic               display_measured, display_measured_next;

  // Input register stage
  logic     stage_valid;
  in_item_t stage_item;
  logic     advance;

  // Per-item decode
  logic            is_digit, is_commit;
  logic [SP_W-1:0] entry_value;
  logic            entry_ok;
  entry_status_t   status;
  logic [DUTY_W-1:0] duty;

  // Result register moves when empty or being taken; input stage follows it.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_setpoint              <= MIN_SP_RST;
      max_setpoint              <= MAX_SP_RST;
      default_setpoint          <= DEF_SP_RST;
      fan_cfg.duty_per_degree   <= GAIN_RST;
      fan_cfg.proportional_span <= SPAN_RST;
      fan_cfg.full_duty         <= FULL_DUTY_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_MIN_SP:    min_setpoint              <= cfg_data[SP_W-1:0];
        REG_MAX_SP:    max_setpoint              <= cfg_data[SP_W-1:0];
        REG_DEF_SP:    default_setpoint          <= cfg_data[SP_W-1:0];
        REG_GAIN:      fan_cfg.duty_per_degree   <= cfg_data[GAIN_W-1:0];
        REG_SPAN:      fan_cfg.proportional_span <= cfg_data[SPAN_W-1:0];
        REG_FULL_DUTY: fan_cfg.full_duty         <= cfg_data[SP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  // Key decode: digits share their low nibble with the ASCII code
  assign is_digit  = stage_item.key_valid && (stage_item.key_code >= KEY_ZERO)
                     && (stage_item.key_code <= KEY_NINE);
  assign is_commit = stage_item.key_valid && (stage_item.key_code == KEY_COMMIT);

  // Held digits to a decimal value, most significant first (x10 as shift-add)
  always_comb begin
    entry_value = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (CNT_W'(i) < digits_held) begin
        entry_value = (entry_value << 3) + (entry_value << 1)
                      + SP_W'(entered_digits[i]);
      end
    end
  end

  // An empty entry never passes; inverted limits reject everything naturally
  assign entry_ok = (digits_held != '0) && (entry_value >= min_setpoint)
                    && (entry_value <= max_setpoint);

  always_comb begin
    entered_digits_next   = entered_digits;
    digits_held_next      = digits_held;
    setpoint_next         = setpoint;
    display_measured_next = display_measured;
    status                = ENTRY_NONE;
    if (is_digit) begin
      display_measured_next = 1'b0;
      // extra digits only switch the display
      if (digits_held < CNT_W'(MAX_DIGITS)) begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (digits_held == CNT_W'(i)) begin
            entered_digits_next[i] = stage_item.key_code[DIGIT_W-1:0];
          end
        end
        digits_held_next = digits_held + CNT_W'(1);
      end
    end else if (is_commit) begin
      if (entry_ok) begin
        setpoint_next         = entry_value;
        display_measured_next = 1'b1;
        status                = ENTRY_ACCEPTED;
      end else begin
        setpoint_next = default_setpoint;
        status        = ENTRY_REJECTED;
      end
      for (int i = 0; i < MAX_DIGITS; i++) begin
        entered_digits_next[i] = '0;
      end
      digits_held_next = '0;
    end
  end

  // Duty uses the setpoint in effect after this item
  tkfc_fan_rule u_fan_rule (
    .temperature (stage_item.temperature),
    .setpoint    (setpoint_next),
    .cfg         (fan_cfg),
    .duty        (duty)
  );

  // State commits when the item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        entered_digits[i] <= '0;
      end
      digits_held      <= '0;
      setpoint         <= DEF_SP_RST;
      display_measured <= 1'b1;
    end else if (stage_valid && advance) begin
      entered_digits   <= entered_digits_next;
      digits_held      <= digits_held_next;
      setpoint         <= setpoint_next;
      display_measured <= display_measured_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_item.fan_duty        <= duty;
      out_item.entry_status    <= status;
      out_item.show_measured   <= display_measured_next;
      out_item.active_setpoint <= setpoint_next;
    end
  end

endmodule

// File: sv/tkfc_fan_rule.sv
// Proportional fan duty from temperature and setpoint, saturated.
module tkfc_fan_rule import tkfc_pkg::*; (
  input  logic [TEMP_W-1:0] temperature,
  input  logic [SP_W-1:0]   setpoint,
  input  fan_cfg_t          cfg,
  output logic [DUTY_W-1:0] duty
);

  logic [TEMP_W-1:0]        diff;
  logic [GAIN_W+TEMP_W-1:0] prod;

  assign diff = temperature - TEMP_W'(setpoint);
  assign prod = (GAIN_W+TEMP_W)'(cfg.duty_per_degree) * (GAIN_W+TEMP_W)'(diff);

  always_comb begin
    if (temperature <= TEMP_W'(setpoint)) begin
      duty = '0;
    end else if (diff > cfg.proportional_span) begin
      duty = DUTY_W'(cfg.full_duty);
    end else if (prod > (GAIN_W+TEMP_W)'(DUTY_CEILING)) begin
      duty = DUTY_CEILING;
    end else begin
      duty = DUTY_W'(prod);
    end
  end

endmodule

// File: sv/tkfc_checker.sv
// Port-level checks for the thermostat fan controller, bound to the top level.
module tkfc_checker import tkfc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid just after reset");

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // Accepted entry always brings the display back to measured
  a_accept_display: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.entry_status == ENTRY_ACCEPTED |-> out_item.show_measured)
    else $error("accepted entry left display in entry mode");

  // Duty never exceeds the ceiling; status code always one of the defined ones
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.fan_duty <= DUTY_CEILING
                  && (out_item.entry_status == ENTRY_NONE
                      || out_item.entry_status == ENTRY_ACCEPTED
                      || out_item.entry_status == ENTRY_REJECTED))
    else $error("duty or status out of range");

endmodule

bind thermostat_keypad_fan_control tkfc_checker u_tkfc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// File: test/thermostat_keypad_fan_control_test.sv
// Self-checking testbench for the thermostat keypad and fan duty controller.
module thermostat_keypad_fan_control_test;
  import tkfc_pkg::*;

  // A long receiver hold-off must fit well inside the watchdog window.
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 4;    // two-stage pipe plus margin
  localparam int PHASE_ITEMS     = 105;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  in_item_t   in_item   = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  out_item_t  out_item;

  thermostat_keypad_fan_control u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller: register file and keypad/setpoint state.
  // Updated at the same clock edges at which the block sees writes and items.
  // ---------------------------------------------------------------------------
  logic [SP_W-1:0]    lim_lo, lim_hi, fallback_sp, full_duty_reg;
  logic [GAIN_W-1:0]  gain_reg;
  logic [SPAN_W-1:0]  span_reg;
  logic [DIGIT_W-1:0] held_digit [2];
  logic [1:0]         held_count;
  logic [SP_W-1:0]    cur_setpoint;
  logic               cur_show_measured;

  out_item_t expected_readings [$];

  int items_sent       = 0;
  int readings_checked = 0;
  int errors           = 0;
  int commits_accepted = 0;
  int commits_rejected = 0;

  // Idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;

  function automatic void reset_shadow();
    lim_lo            = MIN_SP_RST;
    lim_hi            = MAX_SP_RST;
    fallback_sp       = DEF_SP_RST;
    gain_reg          = GAIN_RST;
    span_reg          = SPAN_RST;
    full_duty_reg     = FULL_DUTY_RST;
    held_digit[0]     = '0;
    held_digit[1]     = '0;
    held_count        = '0;
    cur_setpoint      = DEF_SP_RST;
    cur_show_measured = 1'b1;
  endfunction

  // One control period: keypad handling first, then the fan law on the
  // setpoint that is in effect after the key.
  function automatic out_item_t thermostat_period(input in_item_t it);
    out_item_t     r;
    entry_status_t st;
    int            val;
    int            diff;
    int            prod;
    st = ENTRY_NONE;
    if (it.key_valid) begin
      if (it.key_code >= KEY_ZERO && it.key_code <= KEY_NINE) begin
        // any digit selects entry mode, even once the buffer is full
        cur_show_measured = 1'b0;
        if (held_count < MAX_DIGITS_DEF) begin
          held_digit[held_count[0]] = DIGIT_W'(it.key_code - KEY_ZERO);
          held_count++;
        end
      end else if (it.key_code == KEY_COMMIT) begin
        val = (held_count == 1) ? held_digit[0] : held_digit[0] * 10 + held_digit[1];
        // empty commit never passes; inverted limits reject everything
        if (held_count != 0 && val >= lim_lo && val <= lim_hi) begin
          cur_setpoint      = val[SP_W-1:0];
          cur_show_measured = 1'b1;
          st                = ENTRY_ACCEPTED;
          commits_accepted++;
        end else begin
          cur_setpoint = fallback_sp;
          st           = ENTRY_REJECTED;
          commits_rejected++;
        end
        held_digit[0] = '0;
        held_digit[1] = '0;
        held_count    = '0;
      end
    end
    if (it.temperature <= cur_setpoint) begin
      r.fan_duty = '0;
    end else begin
      diff = it.temperature - cur_setpoint;
      if (diff > span_reg) begin
        r.fan_duty = {1'b0, full_duty_reg};
      end else begin
        prod       = gain_reg * diff;
        r.fan_duty = (prod > DUTY_CEILING) ? DUTY_CEILING : prod[DUTY_W-1:0];
      end
    end
    r.entry_status    = st;
    r.show_measured   = cur_show_measured;
    r.active_setpoint = cur_setpoint;
    return r;
  endfunction

  task automatic report_field(input string fname, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: register writes, accepted items and accepted readings, all
  // sampled at the rising edge so values are the pre-edge ones.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      reset_shadow();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_MIN_SP:    lim_lo        = cfg_data[SP_W-1:0];
          REG_MAX_SP:    lim_hi        = cfg_data[SP_W-1:0];
          REG_DEF_SP:    fallback_sp   = cfg_data[SP_W-1:0];
          REG_GAIN:      gain_reg      = cfg_data[GAIN_W-1:0];
          REG_SPAN:      span_reg      = cfg_data[SPAN_W-1:0];
          REG_FULL_DUTY: full_duty_reg = cfg_data[SP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_readings.push_back(thermostat_period(in_item));
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: reading with nothing expected: duty %0d status %0d setpoint %0d",
                   $time, out_item.fan_duty, out_item.entry_status, out_item.active_setpoint);
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          report_field("fan_duty", want.fan_duty, out_item.fan_duty);
          report_field("entry_status", want.entry_status, out_item.entry_status);
          report_field("show_measured", want.show_measured, out_item.show_measured);
          report_field("active_setpoint", want.active_setpoint, out_item.active_setpoint);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off counted out here on request.
  always @(posedge clk) begin : receiver
    int hold_left;
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run after too long with no handshake on either side.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d readings outstanding", $time,
               expected_readings.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task is entered just after a rising edge.
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk(input int temp, input bit kv, input logic [KEY_W-1:0] code);
    in_item_t it;
    it.temperature = temp[TEMP_W-1:0];
    it.key_valid   = kv;
    it.key_code    = code;
    return it;
  endfunction

  // Half the samples sit around the setpoint so both fan regions get hit.
  function automatic int rand_temp();
    int t;
    if ($urandom_range(0, 1) == 0)
      return $urandom_range(0, 255);
    t = int'(cur_setpoint) + $urandom_range(0, int'(span_reg) + 6) - 3;
    return (t < 0) ? 0 : (t > 255) ? 255 : t;
  endfunction

  // Valid stays high across back-to-back items; it only drops for a gap.
  task automatic send_item(input in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_key(input logic [KEY_W-1:0] code);
    send_item(mk(rand_temp(), 1'b1, code));
  endtask

  // Wait for every outstanding reading, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Only called with the block idle (after drain).
  task automatic set_registers(input logic [7:0] lo, input logic [7:0] hi,
                               input logic [7:0] dflt, input logic [7:0] g,
                               input logic [7:0] sp, input logic [7:0] full);
    write_reg(REG_MIN_SP, lo);
    write_reg(REG_MAX_SP, hi);
    write_reg(REG_DEF_SP, dflt);
    write_reg(REG_GAIN, g);
    write_reg(REG_SPAN, sp);
    write_reg(REG_FULL_DUTY, full);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fan law at reset settings (setpoint 25, gain 10, span 10, full 100).
  task automatic test_reset_fan_law();
    send_item(mk(0, 1'b0, 8'h00));
    send_item(mk(255, 1'b0, 8'hFF));
    send_item(mk(25, 1'b0, KEY_COMMIT));  // key ignored without key_valid
    send_item(mk(26, 1'b0, 8'h00));
    send_item(mk(35, 1'b0, 8'h00));       // span edge, still proportional
    send_item(mk(36, 1'b0, 8'h00));       // just past span: full duty
    send_item(mk(30, 1'b0, KEY_ZERO + 8'd5));
  endtask

  // Digit collection, overflow digits, commits at both limits, empty commit,
  // rejection by range and keys that are neither digit nor commit.
  task automatic test_keypad_entry();
    send_item(mk(40, 1'b1, KEY_ZERO + 8'd2));
    send_item(mk(40, 1'b1, KEY_ZERO + 8'd2));
    send_item(mk(40, 1'b1, KEY_ZERO + 8'd7));  // third digit dropped
    send_item(mk(40, 1'b1, KEY_COMMIT));       // 22 accepted
    send_item(mk(40, 1'b1, KEY_COMMIT));       // nothing held: rejected
    send_item(mk(31, 1'b1, KEY_NINE));
    send_item(mk(31, 1'b1, KEY_COMMIT));       // 9 below minimum
    send_item(mk(50, 1'b1, KEY_ZERO - 8'd1));
    send_item(mk(50, 1'b1, KEY_NINE + 8'd1));
    send_item(mk(50, 1'b1, 8'hFF));
    send_item(mk(50, 1'b1, 8'h00));
    send_item(mk(45, 1'b1, KEY_ZERO + 8'd3));
    send_item(mk(45, 1'b1, KEY_ZERO));
    send_item(mk(45, 1'b1, KEY_COMMIT));       // 30, the maximum
    send_item(mk(20, 1'b1, KEY_ZERO + 8'd1));
    send_item(mk(20, 1'b1, KEY_ZERO + 8'd5));
    send_item(mk(20, 1'b1, KEY_COMMIT));       // 15, the minimum
    send_item(mk(60, 1'b1, KEY_ZERO + 8'd3));
    send_item(mk(60, 1'b1, KEY_ZERO + 8'd1));
    send_item(mk(60, 1'b1, KEY_COMMIT));       // 31 above maximum
  endtask

  // All-ones and all-zero register values, including a default above 99.
  task automatic test_register_extremes();
    drain();
    set_registers(8'd0, 8'd99, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(mk(255, 1'b1, KEY_ZERO));
    send_item(mk(255, 1'b1, KEY_COMMIT));      // 0 accepted, product saturates
    send_item(mk(1, 1'b1, KEY_NINE));
    send_item(mk(1, 1'b1, KEY_NINE));
    send_item(mk(150, 1'b1, KEY_COMMIT));      // 99 accepted
    send_item(mk(255, 1'b1, KEY_COMMIT));      // fallback of 127
    send_item(mk(128, 1'b0, 8'h00));
    drain();
    set_registers(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(mk(0, 1'b1, KEY_ZERO));
    send_item(mk(1, 1'b1, KEY_COMMIT));        // past a zero span: full duty 0
    send_item(mk(9, 1'b1, KEY_ZERO + 8'd1));
    send_item(mk(9, 1'b1, KEY_COMMIT));
  endtask

  // Minimum above maximum: every entry bounces to the default.
  task automatic test_inverted_limits();
    drain();
    set_registers(8'd60, 8'd40, 8'd50, 8'd10, 8'd10, 8'd100);
    send_item(mk(55, 1'b1, KEY_ZERO + 8'd5));
    send_item(mk(55, 1'b1, KEY_ZERO));
    send_item(mk(55, 1'b1, KEY_COMMIT));
    send_item(mk(70, 1'b1, KEY_ZERO + 8'd6));
    send_item(mk(70, 1'b1, KEY_ZERO));
    send_item(mk(70, 1'b1, KEY_COMMIT));
  endtask

  // Mostly complete entries (digits, then commit) aimed inside the limits,
  // mixed with key-less periods and raw keypad noise.
  task automatic run_traffic(input int n);
    int stop_at;
    int kind;
    int ndig;
    int tgt;
    int top;
    logic [KEY_W-1:0] keys [3];
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        top = (lim_hi > 99) ? 99 : lim_hi;
        if (lim_lo <= top && $urandom_range(0, 9) < 7)
          tgt = $urandom_range(lim_lo, top);
        else
          tgt = $urandom_range(0, 99);
        ndig = $urandom_range(0, 9);
        ndig = (ndig == 0) ? 0 : (ndig < 4) ? 1 : (ndig < 9) ? 2 : 3;
        if (ndig == 1) begin
          keys[0] = KEY_ZERO + KEY_W'((tgt < 10) ? tgt : $urandom_range(0, 9));
        end else begin
          keys[0] = KEY_ZERO + KEY_W'(tgt / 10);
          keys[1] = KEY_ZERO + KEY_W'(tgt % 10);
          keys[2] = KEY_ZERO + KEY_W'($urandom_range(0, 9));
        end
        for (int i = 0; i < ndig; i++) begin
          send_key(keys[i]);
          if ($urandom_range(0, 4) == 0)
            send_item(mk(rand_temp(), 1'b0, KEY_W'($urandom)));
        end
        send_key(KEY_COMMIT);
      end else if (kind < 85) begin
        send_item(mk(rand_temp(), 1'b0, KEY_W'($urandom)));
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(mk(rand_temp(), 1'($urandom_range(0, 1)), KEY_W'($urandom)));
      end else begin
        send_key(KEY_ZERO + KEY_W'($urandom_range(0, 9)));
      end
    end
  endtask

  // Four idling phases, each over three random register settings.
  task automatic test_random_traffic();
    logic [7:0] lo, hi;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int s = 0; s < 3; s++) begin
        drain();
        lo = 8'($urandom_range(0, 99));
        hi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, lo))
                                         : 8'($urandom_range(lo, 99));
        // occasional out-of-range values exercise the top register bits
        set_registers(lo, hi,
                      8'(($urandom_range(0, 7) == 0) ? $urandom_range(100, 255)
                                                     : $urandom_range(0, 99)),
                      8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 100)),
                      8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 150)),
                      8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 100)));
        run_traffic(PHASE_ITEMS);
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // items back to back, so the pipe fills and in_ready drops.
  task automatic test_output_hold_off();
    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    @(posedge clk);
    run_traffic(30);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_fan_law();
    test_keypad_entry();
    test_register_extremes();
    test_inverted_limits();
    test_random_traffic();
    test_output_hold_off();
    drain();
    $display("Covered edge registers, inverted limits, stalls: %0d items, %0d readings",
             items_sent, readings_checked);
    $display("Setpoint commits: %0d accepted, %0d rejected; %0d field mismatches",
             commits_accepted, commits_rejected, errors);
    if (errors == 0 && expected_readings.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
